[rtl/ft12_pkg.sv]
// shared types and constants for the ft1.2 response frame checker
// no dependencies; used by ft12_parser and ft12_response_frame_checker
package ft12_pkg;

  localparam logic [7:0] START_FIXED    = 8'h10;
  localparam logic [7:0] START_VARIABLE = 8'h68;
  localparam logic [7:0] BYTE_MASK      = 8'hff;
  localparam int unsigned ACD_BIT       = 5;

  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    ST_OK_ACD_CLR = 3'd0,
    ST_OK_ACD_SET = 3'd1,
    ST_BAD_CSUM   = 3'd2,
    ST_ADDR_MISS  = 3'd3,
    ST_FUNC_REJ   = 3'd4,
    ST_BAD_LEN    = 3'd5
  } status_t;

  typedef struct packed {
    status_t    status;
    logic       variable_frame;
    logic [7:0] control_byte;
    logic [3:0] function_code;
    logic [7:0] user_data_length;
  } verdict_t;

endpackage

[rtl/ft12_parser.sv]
// frame parser: start byte hunt, field capture, checksum and verdict
// depends on ft12_pkg
module ft12_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        station_address,
  output logic              emit,
  output ft12_pkg::verdict_t verdict
);

  typedef enum logic [1:0] {
    PH_HUNT     = 2'd0,
    PH_FIXED    = 2'd1,
    PH_VARIABLE = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [8:0] idx_r, idx_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] ctrl_r, ctrl_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic       bad_r, bad_nxt;
  logic       var_r, var_nxt;

  logic [8:0] len9;
  logic       func_ok;
  logic       short_len;

  assign len9 = {1'b0, len_r};

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    ctrl_nxt  = ctrl_r;
    addr_nxt  = addr_r;
    bad_nxt   = bad_r;
    var_nxt   = var_r;
    emit      = 1'b0;
    unique case (phase_r)
      PH_FIXED: begin
        case (idx_r)
          9'd1: begin
            ctrl_nxt = rx_byte;
            sum_nxt  = rx_byte;
          end
          9'd2: begin
            addr_nxt = rx_byte;
            sum_nxt  = sum_r + rx_byte;
          end
          9'd3: begin
            bad_nxt = (rx_byte != sum_r);
          end
          default: begin
            emit = 1'b1;
          end
        endcase
        if (emit) begin
          phase_nxt = PH_HUNT;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 9'd1;
        end
      end
      PH_VARIABLE: begin
        if (idx_r == 9'd1) len_nxt = rx_byte;
        if (idx_r == 9'd4) ctrl_nxt = rx_byte;
        if (idx_r == 9'd5) addr_nxt = rx_byte;
        // sum runs over control, address and user data; the byte after is the checksum
        if (idx_r >= 9'd4 && len_r >= 8'd2) begin
          if (idx_r <= len9 + 9'd3) begin
            sum_nxt = sum_r + rx_byte;
          end else if (idx_r == len9 + 9'd4) begin
            bad_nxt = (rx_byte != sum_r);
          end
        end
        if (idx_r >= 9'd5 && idx_r >= len9 + 9'd5) begin
          emit      = 1'b1;
          phase_nxt = PH_HUNT;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 9'd1;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (rx_byte == ft12_pkg::START_FIXED || rx_byte == ft12_pkg::START_VARIABLE) begin
          phase_nxt = (rx_byte == ft12_pkg::START_FIXED) ? PH_FIXED : PH_VARIABLE;
          var_nxt   = (rx_byte == ft12_pkg::START_VARIABLE);
          idx_nxt   = 9'd1;
          len_nxt   = '0;
          sum_nxt   = '0;
          ctrl_nxt  = '0;
          addr_nxt  = '0;
          bad_nxt   = 1'b0;
        end
      end
    endcase
  end

  // accepted responses: 0, 1, 8, 9, 11
  always_comb begin
    case (ctrl_nxt[3:0])
      4'd0, 4'd1, 4'd8, 4'd9, 4'd11: func_ok = 1'b1;
      default:                       func_ok = 1'b0;
    endcase
  end

  assign short_len = var_r && (len_r < 8'd2);

  always_comb begin
    if (short_len) begin
      verdict.status = ft12_pkg::ST_BAD_LEN;
    end else if (bad_nxt) begin
      verdict.status = ft12_pkg::ST_BAD_CSUM;
    end else if (addr_nxt != station_address) begin
      verdict.status = ft12_pkg::ST_ADDR_MISS;
    end else if (!func_ok) begin
      verdict.status = ft12_pkg::ST_FUNC_REJ;
    end else if (ctrl_nxt[ft12_pkg::ACD_BIT]) begin
      verdict.status = ft12_pkg::ST_OK_ACD_SET;
    end else begin
      verdict.status = ft12_pkg::ST_OK_ACD_CLR;
    end
    verdict.variable_frame   = var_r;
    verdict.control_byte     = ctrl_nxt;
    verdict.function_code    = ctrl_nxt[3:0];
    verdict.user_data_length = (var_r && !short_len) ? (len_r - 8'd2) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      idx_r   <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      ctrl_r  <= '0;
      addr_r  <= '0;
      bad_r   <= 1'b0;
      var_r   <= 1'b0;
    end else if (byte_valid) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      ctrl_r  <= ctrl_nxt;
      addr_r  <= addr_nxt;
      bad_r   <= bad_nxt;
      var_r   <= var_nxt;
    end
  end

endmodule

[rtl/ft12_response_frame_checker.sv]
// top level of the ft1.2 response frame checker: ports, config register, output queue
// depends on ft12_pkg and ft12_parser
//
// usage:
//  - in_* takes one received serial byte per word; bytes outside a frame are dropped
//  - out_* gives one verdict word per complete fixed (0x10) or variable (0x68) frame
//  - cfg_* writes the station address that responses must carry; cfg_ready is always
//    high, write only while no frame is in progress
// the verdict is registered into the output queue as the frame's last byte is taken
// throughput: one byte per cycle while in_tready is high; the parser state updates in the cycle the byte is taken
// the output side has a result register plus a skid entry, so bytes keep flowing while
//  a verdict waits; in_tready drops only when both entries hold unread verdicts
// reset (rst_n low, synchronous): parser back to hunting, output queue empty,
//  station address 1
// a stalled receiver holds out_tdata stable until it is taken
module ft12_response_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] status, [3] variable_frame, [11:4] control_byte,
                                  // [15:12] function_code, [23:16] user_data_length
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // [7:0] station_address
);

  logic [7:0] station_r;
  logic       accept;
  logic       emit;
  logic       push;
  logic       pop;

  ft12_pkg::verdict_t verdict;
  ft12_pkg::verdict_t out_r;
  ft12_pkg::verdict_t skid_r;
  logic               out_v_r;
  logic               skid_v_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_v_r;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && emit;
  assign pop       = out_v_r && out_tready;

  ft12_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .byte_valid      (accept),
    .rx_byte         (in_tdata),
    .station_address (station_r),
    .emit            (emit),
    .verdict         (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      station_r <= cfg_data;
    end
  end

  // two-entry queue: out_r is the head, skid_r only fills while the head is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || pop) begin
        out_v_r  <= skid_v_r || push;
        skid_v_r <= 1'b0;
      end else if (push) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      out_r <= skid_v_r ? skid_r : verdict;
    end
    if (out_v_r && !pop && push) begin
      skid_r <= verdict;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.user_data_length, out_r.function_code, out_r.control_byte,
                       out_r.variable_frame, 3'(out_r.status)};

endmodule
